// ===== sv/chm_pkg.sv =====
// Shared constants, codes and the attenuation weight table for the calorimeter hit merger.
`timescale 1ns / 1ps
package chm_pkg;

    localparam int CHM_NUM_CHANNELS     = 256;
    localparam int CHM_HITS_PER_CHANNEL = 16;

    localparam int CH_W       = 8;
    localparam int ENERGY_W   = 24;
    localparam int TIME_W     = 24;
    localparam int DEPTH_W    = 13;
    localparam int WINDOW_W   = 16;
    localparam int HALF_W     = 13;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 4;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_WINDOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH      = 2'd2;

    localparam logic [WINDOW_W-1:0]   MERGE_WINDOW_RST     = 16'd1200;
    localparam logic [ENERGY_W-1:0]   ENERGY_THRESHOLD_RST = 24'd20000;
    localparam logic [HALF_W-1:0]     HALF_LENGTH_RST      = 13'd2304;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_MERGED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CREATED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READOUT = 3'd4;

    // ceil(2^20 / 13): exact floor division for values below 1024
    localparam logic [16:0] TIME_DIV_MULT = 17'd80660;

    // weighted-time divider widths
    localparam int DIV_N_W = 50;
    localparam int DIV_D_W = 25;
    localparam int DIV_Q_W = 24;

    localparam logic [63:0] ATTEN_RATIO = 64'd4277108830;

    typedef logic [15:0] weight_tbl_t [256];

    // exp(-k/240) in Q0.16, built by repeated Q0.32 multiplication at elaboration
    function automatic weight_tbl_t build_weights();
        weight_tbl_t tbl;
        logic [63:0] acc;
        logic [63:0] w;
        acc = 64'h1_0000_0000;
        for (int k = 0; k < 256; k++) begin
            w = (acc + 64'd32768) >> 16;
            tbl[k] = (w > 64'd65535) ? 16'hFFFF : w[15:0];
            acc = (acc * ATTEN_RATIO + 64'h8000_0000) >> 32;
        end
        return tbl;
    endfunction

    localparam weight_tbl_t WEIGHT_TABLE = build_weights();

endpackage

// ===== sv/chm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the energy-weighted hit time.
`timescale 1ns / 1ps
module chm_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [chm_pkg::DIV_N_W-1:0]   dividend,
    input  logic [chm_pkg::DIV_D_W-1:0]   divisor,
    output logic                          done,
    output logic [chm_pkg::DIV_Q_W-1:0]   quotient
);
    import chm_pkg::*;

    localparam int STEP_W = $clog2(DIV_Q_W);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [DIV_D_W-1:0]  rem_reg;
    logic [DIV_D_W-1:0]  den_reg;
    logic [DIV_Q_W-1:0]  quo_reg;

    logic [DIV_D_W:0]    trial;
    logic                ge;

    assign trial = {rem_reg, quo_reg[DIV_Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient is known to fit 24 bits, so the upper dividend bits start below the divisor
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIV_D_W'(dividend[DIV_N_W-1:DIV_Q_W]);
            quo_reg <= dividend[DIV_Q_W-1:0];
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? DIV_D_W'(trial - {1'b0, den_reg}) : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/calorimeter_hit_merger.sv =====
// Top level of the calorimeter hit merger: per-channel hit lists in block memory.
`timescale 1ns / 1ps
// Per-channel hit accumulator. A deposit word (tuser 0) is corrected for distance to the
// readout face and either merged into the first stored hit within the merge window,
// appended, or dropped when the list is full; one result word per deposit. A readout word
// (tuser 1) returns every stored hit at or above threshold, tlast on the final one, and
// empties the channel. After reset a clearing pass over every channel empties the
// count memory before the first word is taken. Items are handled one at a time through a
// single-port hit memory: a deposit scans the stored hits of its channel and waits on the
// bit-serial divider when it merges; a readout reads the stored hits one by one and can
// stall on the result side.
module calorimeter_hit_merger #(
    parameter int NUM_CHANNELS     = chm_pkg::CHM_NUM_CHANNELS,
    parameter int HITS_PER_CHANNEL = chm_pkg::CHM_HITS_PER_CHANNEL
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // channel, deposit_energy, deposit_time, local_depth, zero pad
    input  logic [chm_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit_energy, hit_time
    output logic [chm_pkg::M_TDATA_W-1:0]      m_tdata,
    // status, has_hit
    output logic [chm_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [chm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chm_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import chm_pkg::*;

    localparam int CNT_W      = $clog2(HITS_PER_CHANNEL + 1);
    localparam int HIT_IDX_W  = (HITS_PER_CHANNEL > 1) ? $clog2(HITS_PER_CHANNEL) : 1;
    localparam int CH_IDX_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MEM_ADDR_W = CH_IDX_W + HIT_IDX_W;
    localparam int MEM_DEPTH  = 2 ** MEM_ADDR_W;
    localparam int CNT_DEPTH  = 2 ** CH_IDX_W;
    localparam int ENTRY_W    = ENERGY_W + TIME_W;

    typedef enum logic [11:0] {
        FSM_CLEAR    = 12'b0000_0000_0001,
        FSM_IDLE     = 12'b0000_0000_0010,
        FSM_LOOKUP   = 12'b0000_0000_0100,
        FSM_CORR     = 12'b0000_0000_1000,
        FSM_SCAN     = 12'b0000_0001_0000,
        FSM_MUL      = 12'b0000_0010_0000,
        FSM_SUM      = 12'b0000_0100_0000,
        FSM_DIV      = 12'b0000_1000_0000,
        FSM_WRITE    = 12'b0001_0000_0000,
        FSM_RD_ISSUE = 12'b0010_0000_0000,
        FSM_RD_CHECK = 12'b0100_0000_0000,
        FSM_EMIT     = 12'b1000_0000_0000
    } fsm_t;

    fsm_t state_reg, state_next;

    // configuration
    logic [WINDOW_W-1:0] merge_window_reg;
    logic [ENERGY_W-1:0] threshold_reg;
    logic [HALF_W-1:0]   half_length_reg;

    // captured word
    logic                      req_reg;
    logic [CH_W-1:0]           ch_reg;
    logic [ENERGY_W-1:0]       energy_reg;
    logic [TIME_W-1:0]         time_reg;
    logic signed [DEPTH_W-1:0] depth_reg;

    // memories
    logic [ENTRY_W-1:0] hit_mem [MEM_DEPTH];
    logic [CNT_W-1:0]   cnt_mem [CNT_DEPTH];
    logic [ENTRY_W-1:0] mem_q_reg;
    logic [CNT_W-1:0]   cnt_q_reg;

    logic                  mem_we, mem_re;
    logic [MEM_ADDR_W-1:0] mem_addr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic                  cnt_we, cnt_re;
    logic [CH_IDX_W-1:0]   cnt_addr;
    logic [CNT_W-1:0]      cnt_wdata;

    // working registers
    logic [CH_IDX_W-1:0]  clr_reg;
    logic [15:0]          w_reg;
    logic [TIME_W-1:0]    tcorr_reg;
    logic [ENERGY_W-1:0]  ecorr_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic [CNT_W-1:0]     rd_idx_reg;
    logic                 rd_pend_reg;
    logic [HIT_IDX_W-1:0] hit_idx_reg;
    logic [DIV_D_W-1:0]   sum_reg;
    logic [2*TIME_W-1:0]  p_old_reg;
    logic [2*TIME_W-1:0]  p_new_reg;
    logic                 pend_reg;

    // pending result
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_has_reg;
    logic [ENERGY_W-1:0] res_e_reg;
    logic [TIME_W-1:0]   res_t_reg;
    logic                res_last_reg;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic                 m_tlast_reg;
    logic                 out_load;
    logic                 out_free;

    // datapath
    logic                 accept;
    logic [CH_IDX_W-1:0]  ch_idx;
    logic                 bad_ch;
    logic signed [14:0]   d_s;
    logic [13:0]          face_dist;
    logic [14:0]          k_sum;
    logic [14:0]          y_sum;
    logic [26:0]          q_prod;
    logic [TIME_W:0]      tcorr_sum;
    logic [TIME_W-1:0]    tcorr;
    logic [39:0]          ecorr_prod;
    logic [ENERGY_W-1:0]  q_e;
    logic [TIME_W-1:0]    q_t;
    logic [TIME_W-1:0]    diff;
    logic                 hit_match;
    logic [DIV_D_W-1:0]   sum;
    logic [DIV_N_W-1:0]   num;
    logic                 qualifies;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_q;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign ch_idx   = CH_IDX_W'(ch_reg);
    assign bad_ch   = int'(ch_reg) >= NUM_CHANNELS;

    // distance to readout face, negative taken as zero
    assign d_s       = $signed({2'b00, half_length_reg}) - 15'(depth_reg);
    assign face_dist = d_s[14] ? '0 : d_s[13:0];
    assign k_sum     = {1'b0, face_dist} + 15'd32;
    // (face_dist + 104) / 208 as ((face_dist + 104) >> 4) / 13
    assign y_sum  = {1'b0, face_dist} + 15'd104;
    assign q_prod = 27'(y_sum[13:4]) * 27'(TIME_DIV_MULT);
    assign tcorr_sum = {1'b0, time_reg} + (TIME_W + 1)'(q_prod[26:20]);
    assign tcorr     = tcorr_sum[TIME_W] ? '1 : tcorr_sum[TIME_W-1:0];

    assign ecorr_prod = 40'(energy_reg) * 40'(w_reg) + 40'd32768;

    assign q_e       = mem_q_reg[ENERGY_W-1:0];
    assign q_t       = mem_q_reg[ENTRY_W-1:ENERGY_W];
    assign diff      = (q_t > tcorr_reg) ? (q_t - tcorr_reg) : (tcorr_reg - q_t);
    assign hit_match = rd_pend_reg && (diff < TIME_W'(merge_window_reg));
    assign sum       = DIV_D_W'(q_e) + DIV_D_W'(ecorr_reg);
    assign num       = DIV_N_W'(p_old_reg) + DIV_N_W'(p_new_reg) + DIV_N_W'(sum_reg >> 1);
    assign qualifies = q_e >= threshold_reg;

    // control: next state and memory port drive
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = {ch_idx, issue_reg[HIT_IDX_W-1:0]};
        mem_wdata  = {res_t_reg, res_e_reg};
        cnt_we     = 1'b0;
        cnt_re     = 1'b0;
        cnt_addr   = ch_idx;
        cnt_wdata  = '0;
        out_load   = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            FSM_CLEAR: begin
                cnt_we   = 1'b1;
                cnt_addr = clr_reg;
                if (clr_reg == CH_IDX_W'(NUM_CHANNELS - 1)) state_next = FSM_IDLE;
            end
            FSM_IDLE: begin
                s_tready = 1'b1;
                cnt_re   = 1'b1;
                cnt_addr = CH_IDX_W'(s_tdata[CH_W-1:0]);
                if (s_tvalid) state_next = FSM_LOOKUP;
            end
            FSM_LOOKUP: begin
                if (bad_ch || (!req_reg && energy_reg == '0)) begin
                    state_next = FSM_EMIT;
                end else if (req_reg) begin
                    cnt_we     = 1'b1;
                    state_next = FSM_RD_ISSUE;
                end else begin
                    state_next = FSM_CORR;
                end
            end
            FSM_CORR: state_next = FSM_SCAN;
            FSM_SCAN: begin
                if (hit_match) begin
                    state_next = FSM_MUL;
                end else if (issue_reg < cnt_q_reg) begin
                    mem_re = 1'b1;
                end else begin
                    if (cnt_q_reg < CNT_W'(HITS_PER_CHANNEL)) begin
                        mem_we    = 1'b1;
                        mem_addr  = {ch_idx, cnt_q_reg[HIT_IDX_W-1:0]};
                        mem_wdata = {tcorr_reg, ecorr_reg};
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_q_reg + 1'b1;
                    end
                    state_next = FSM_EMIT;
                end
            end
            FSM_MUL: state_next = FSM_SUM;
            FSM_SUM: begin
                if (sum_reg != '0) begin
                    div_start  = 1'b1;
                    state_next = FSM_DIV;
                end else begin
                    state_next = FSM_WRITE;
                end
            end
            FSM_DIV: if (div_done) state_next = FSM_WRITE;
            FSM_WRITE: begin
                mem_we     = 1'b1;
                mem_addr   = {ch_idx, hit_idx_reg};
                state_next = FSM_EMIT;
            end
            FSM_RD_ISSUE: begin
                if (issue_reg < cnt_q_reg) begin
                    mem_re     = 1'b1;
                    state_next = FSM_RD_CHECK;
                end else begin
                    state_next = FSM_EMIT;
                end
            end
            FSM_RD_CHECK: begin
                if (!qualifies || !pend_reg) begin
                    state_next = FSM_RD_ISSUE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = FSM_RD_ISSUE;
                end
            end
            FSM_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == FSM_CLEAR) clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            merge_window_reg <= MERGE_WINDOW_RST;
            threshold_reg    <= ENERGY_THRESHOLD_RST;
            half_length_reg  <= HALF_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MERGE_WINDOW:     merge_window_reg <= cfg_wr_data[WINDOW_W-1:0];
                REG_ENERGY_THRESHOLD: threshold_reg    <= cfg_wr_data[ENERGY_W-1:0];
                REG_HALF_LENGTH:      half_length_reg  <= cfg_wr_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // memories, one port each, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) hit_mem[mem_addr] <= mem_wdata;
        if (mem_re) mem_q_reg <= hit_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
        if (cnt_re) cnt_q_reg <= cnt_mem[cnt_addr];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg     <= s_tuser;
            ch_reg      <= s_tdata[CH_W-1:0];
            energy_reg  <= s_tdata[31:8];
            time_reg    <= s_tdata[55:32];
            depth_reg   <= s_tdata[68:56];
            issue_reg   <= '0;
            rd_pend_reg <= 1'b0;
        end
        case (state_reg)
            FSM_LOOKUP: begin
                w_reg        <= WEIGHT_TABLE[k_sum[13:6]];
                tcorr_reg    <= tcorr;
                pend_reg     <= 1'b0;
                res_has_reg  <= 1'b0;
                res_e_reg    <= '0;
                res_t_reg    <= '0;
                res_last_reg <= 1'b1;
                res_status_reg <= req_reg ? ST_READOUT : ST_IGNORED;
            end
            FSM_CORR: ecorr_reg <= ecorr_prod[39:16];
            FSM_SCAN: begin
                if (hit_match) begin
                    hit_idx_reg <= rd_idx_reg[HIT_IDX_W-1:0];
                end else if (issue_reg < cnt_q_reg) begin
                    rd_idx_reg  <= issue_reg;
                    issue_reg   <= issue_reg + 1'b1;
                    rd_pend_reg <= 1'b1;
                end else if (cnt_q_reg < CNT_W'(HITS_PER_CHANNEL)) begin
                    res_status_reg <= ST_CREATED;
                    res_has_reg    <= 1'b1;
                    res_e_reg      <= ecorr_reg;
                    res_t_reg      <= tcorr_reg;
                end else begin
                    res_status_reg <= ST_FULL;
                end
            end
            FSM_MUL: begin
                p_old_reg <= (2 * TIME_W)'(q_t) * (2 * TIME_W)'(q_e);
                p_new_reg <= (2 * TIME_W)'(tcorr_reg) * (2 * TIME_W)'(ecorr_reg);
                sum_reg   <= sum;
            end
            FSM_SUM: begin
                res_status_reg <= ST_MERGED;
                res_has_reg    <= 1'b1;
                res_e_reg      <= sum_reg[DIV_D_W-1] ? '1 : sum_reg[ENERGY_W-1:0];
                res_t_reg      <= q_t;
            end
            FSM_DIV: if (div_done) res_t_reg <= div_q;
            FSM_RD_ISSUE: begin
                if (issue_reg < cnt_q_reg) issue_reg <= issue_reg + 1'b1;
            end
            FSM_RD_CHECK: begin
                // hold one qualifying hit back so tlast can mark the final one
                if (qualifies && (!pend_reg || out_free)) begin
                    pend_reg       <= 1'b1;
                    res_status_reg <= ST_READOUT;
                    res_has_reg    <= 1'b1;
                    res_e_reg      <= q_e;
                    res_t_reg      <= q_t;
                    res_last_reg   <= 1'b0;
                end
            end
            FSM_EMIT: ;
            default: ;
        endcase
        if (state_reg == FSM_RD_ISSUE && !(issue_reg < cnt_q_reg)) res_last_reg <= 1'b1;
    end

    // result register, frees the input side while a word waits downstream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {res_t_reg, res_e_reg};
            m_tuser_reg <= {res_has_reg, res_status_reg};
            m_tlast_reg <= res_last_reg;
        end
    end

    chm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the calorimeter hit merger: random and directed words.
`timescale 1ns / 1ps
module tb_top;
    import chm_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic        has_hit;
        logic [23:0] energy;
        logic [23:0] htime;
        logic        last;
    } hit_result_t;

    typedef struct packed {
        logic        readout;
        logic [7:0]  channel;
        logic [23:0] energy;
        logic [23:0] dtime;
        logic [12:0] depth;
    } hit_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic m_tlast;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    always #5 aclk = ~aclk;

    calorimeter_hit_merger u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    // predictor state
    logic [15:0] win_q;
    logic [23:0] thresh_q;
    logic [12:0] half_q;
    int          hits_in[256];
    logic [23:0] hit_e[256][16];
    logic [23:0] hit_t[256][16];

    hit_req_t    pending_words[$];
    hit_result_t expected_hits[$];
    int          fail_cnt = 0;

    function automatic logic [15:0] atten_w(int k);
        logic [63:0] acc;
        logic [63:0] w;
        acc = 64'h1_0000_0000;
        for (int i = 0; i < k; i++) acc = (acc * 64'd4277108830 + 64'h8000_0000) >> 32;
        w = (acc + 64'd32768) >> 16;
        return (w > 64'd65535) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic hit_result_t mk(logic [2:0] st, logic h, logic [23:0] e,
                                       logic [23:0] t, logic l);
        hit_result_t r;
        r.status = st; r.has_hit = h; r.energy = e; r.htime = t; r.last = l;
        return r;
    endfunction

    task automatic predict_hits(hit_req_t q);
        int ch, n, k, i, d, face_dist;
        logic [63:0] ec, tc, sum, num;
        logic [15:0] w;
        logic [23:0] df;
        ch = q.channel;
        if (q.readout) begin
            n = hits_in[ch];
            k = 0;
            for (i = 0; i < n; i++)
                if (hit_e[ch][i] >= thresh_q) begin
                    expected_hits.push_back(mk(ST_READOUT, 1, hit_e[ch][i], hit_t[ch][i], 0));
                    k++;
                end
            hits_in[ch] = 0;
            if (k == 0) expected_hits.push_back(mk(ST_READOUT, 0, 0, 0, 1));
            else expected_hits[$].last = 1;
            return;
        end
        if (q.energy == 0) begin
            expected_hits.push_back(mk(ST_IGNORED, 0, 0, 0, 1));
            return;
        end
        d = int'(half_q) - int'($signed(q.depth));
        face_dist = d < 0 ? 0 : d;
        w = atten_w((face_dist + 32) >> 6);
        ec = (64'(q.energy) * w + 64'd32768) >> 16;
        tc = 64'(q.dtime) + 64'((face_dist + 104) / 208);
        if (tc > 64'hFFFFFF) tc = 64'hFFFFFF;
        n = hits_in[ch];
        for (i = 0; i < n; i++) begin
            df = (hit_t[ch][i] > tc[23:0]) ? hit_t[ch][i] - tc[23:0] : tc[23:0] - hit_t[ch][i];
            if (df < win_q) break;
        end
        if (i < n) begin
            sum = 64'(hit_e[ch][i]) + ec;
            if (sum != 0) begin
                num = 64'(hit_t[ch][i]) * hit_e[ch][i] + tc * ec;
                hit_t[ch][i] = 24'((num + sum / 2) / sum);
            end
            hit_e[ch][i] = (sum > 64'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
            expected_hits.push_back(mk(ST_MERGED, 1, hit_e[ch][i], hit_t[ch][i], 1));
        end else if (n < 16) begin
            hit_e[ch][n] = ec[23:0];
            hit_t[ch][n] = tc[23:0];
            hits_in[ch] = n + 1;
            expected_hits.push_back(mk(ST_CREATED, 1, ec[23:0], tc[23:0], 1));
        end else begin
            expected_hits.push_back(mk(ST_FULL, 0, 0, 0, 1));
        end
    endtask

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_hits({s_tuser, s_tdata[7:0], s_tdata[31:8], s_tdata[55:32],
                              s_tdata[68:56]});
                void'(pending_words.pop_front());
            end
            if ((s_tvalid && !s_tready) || pending_words.size() == 0) begin
                // hold current word or stay idle
                if (!(s_tvalid && !s_tready)) s_tvalid <= 1'b0;
            end else if (s_tvalid && s_tready && pending_words.size() > 0
                         && burst_left > 0) begin
                burst_left <= burst_left - 1;
                s_tuser <= pending_words[0].readout;
                s_tdata <= {3'd0, pending_words[0].depth, pending_words[0].dtime,
                            pending_words[0].energy, pending_words[0].channel};
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (!s_tvalid || s_tready) begin
                if (burst_left == 0 && $urandom_range(0, 3) == 0) begin
                    gap_left <= $urandom_range(1, 30);
                    s_tvalid <= 1'b0;
                    burst_left <= $urandom_range(1, 12);
                end else begin
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_words[0].readout;
                    s_tdata <= {3'd0, pending_words[0].depth, pending_words[0].dtime,
                                pending_words[0].energy, pending_words[0].channel};
                end
            end
        end
    end

    // receiver stall pattern
    int rx_phase = 0;
    int rx_mode = 0;
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1;
        if (rx_phase % 64 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_phase % 5) != 0;
            default: m_tready <= $urandom_range(0, 7) == 0;
        endcase
    end

    // monitor
    hit_result_t got, want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = mk(m_tuser[2:0], m_tuser[3], m_tdata[23:0], m_tdata[47:24], m_tlast);
            if (expected_hits.size() == 0) begin
                $error("unexpected result word status=%0d", got.status);
                fail_cnt++;
            end else begin
                want = expected_hits.pop_front();
                if (got.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, got.status); fail_cnt++;
                end
                if (got.has_hit !== want.has_hit) begin
                    $error("has_hit exp %0d got %0d", want.has_hit, got.has_hit); fail_cnt++;
                end
                if (got.energy !== want.energy) begin
                    $error("hit_energy exp %0d got %0d", want.energy, got.energy); fail_cnt++;
                end
                if (got.htime !== want.htime) begin
                    $error("hit_time exp %0d got %0d", want.htime, got.htime); fail_cnt++;
                end
                if (got.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last); fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer (covers the post-reset clearing pass)
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic hit_req_t dep(int ch, logic [23:0] e, logic [23:0] t, int z);
        hit_req_t q;
        q.readout = 0; q.channel = ch[7:0]; q.energy = e; q.dtime = t; q.depth = z[12:0];
        return q;
    endfunction

    function automatic hit_req_t rdo(int ch);
        hit_req_t q;
        q = '0; q.readout = 1; q.channel = ch[7:0];
        q.energy = $urandom; q.dtime = $urandom;
        q.depth = 13'($signed($urandom_range(0, 4608)) - 2304);
        return q;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MERGE_WINDOW:     win_q = val[15:0];
            REG_ENERGY_THRESHOLD: thresh_q = val;
            default:              half_q = val[12:0];
        endcase
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || expected_hits.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // a cluster of deposits on a few channels, then their readouts
    task automatic random_phase(int count);
        int chs[4];
        int base_t;
        for (int j = 0; j < 4; j++) chs[j] = $urandom_range(0, 255);
        base_t = $urandom_range(0, 24'hFFFFFF);
        for (int i = 0; i < count; i++) begin
            int r, ch, z;
            logic [23:0] e, t;
            r = $urandom_range(0, 99);
            ch = chs[$urandom_range(0, 3)];
            z = $urandom_range(0, 4608) - 2304;
            e = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 200000));
            if ($urandom_range(0, 20) == 0) e = 0;
            t = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                : 24'(base_t + $urandom_range(0, 8000));
            if (r < 12) pending_words.push_back(rdo(ch));
            else if (r < 17) pending_words.push_back(dep($urandom_range(0, 255), e, t, z));
            else pending_words.push_back(dep(ch, e, t, z));
        end
        for (int j = 0; j < 4; j++) pending_words.push_back(rdo(chs[j]));
        drain();
    endtask

    initial begin
        win_q = MERGE_WINDOW_RST; thresh_q = ENERGY_THRESHOLD_RST; half_q = HALF_LENGTH_RST;
        foreach (hits_in[i]) hits_in[i] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, merge, full list, empty readout, zero distance
        pending_words.push_back(dep(0, 24'd0, 24'd5, 0));
        pending_words.push_back(dep(255, 24'hFFFFFF, 24'hFFFFFF, -2304));
        pending_words.push_back(dep(255, 24'hFFFFFF, 24'hFFFFF0, 2304));
        pending_words.push_back(dep(255, 24'd1, 24'hFFFFFF, 0));
        pending_words.push_back(rdo(255));
        pending_words.push_back(dep(3, 24'd50000, 24'd1000, 2304));
        pending_words.push_back(dep(3, 24'd30000, 24'd1500, 2304));
        pending_words.push_back(rdo(3));
        pending_words.push_back(rdo(3));
        for (int i = 0; i < 17; i++)
            pending_words.push_back(dep(7, 24'd25000, 24'(i * 5000), -100));
        pending_words.push_back(rdo(7));
        drain();

        write_reg(REG_HALF_LENGTH, 24'd0);
        write_reg(REG_MERGE_WINDOW, 24'd0);
        write_reg(REG_ENERGY_THRESHOLD, 24'd0);
        pending_words.push_back(dep(9, 24'd1, 24'd0, 2304));
        pending_words.push_back(dep(9, 24'd1, 24'd0, 2304));
        pending_words.push_back(dep(9, 24'd100, 24'd10, -2304));
        pending_words.push_back(rdo(9));
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: begin
                    write_reg(REG_MERGE_WINDOW, 24'hFFFF);
                    write_reg(REG_ENERGY_THRESHOLD, 24'hFFFFFF);
                    write_reg(REG_HALF_LENGTH, 24'd4608);
                end
                1: begin
                    write_reg(REG_MERGE_WINDOW, 24'($urandom_range(0, 4000)));
                    write_reg(REG_ENERGY_THRESHOLD, 24'($urandom_range(0, 60000)));
                    write_reg(REG_HALF_LENGTH, 24'($urandom_range(0, 4608)));
                end
                2: begin
                    write_reg(REG_MERGE_WINDOW, 24'd1200);
                    write_reg(REG_ENERGY_THRESHOLD, 24'd20000);
                    write_reg(REG_HALF_LENGTH, 24'd2304);
                end
                3: begin
                    write_reg(REG_MERGE_WINDOW, 24'd0);
                    write_reg(REG_ENERGY_THRESHOLD, 24'd0);
                end
                default: write_reg(REG_MERGE_WINDOW, 24'($urandom_range(100, 65535)));
            endcase
            random_phase(40);
        end
        if (fail_cnt == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
